// ===== hw/rtl/rlss_pkg.sv =====
package rlss_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int LENGTH_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_ROWS);
  localparam int CNT_W       = $clog2(MAX_ROWS + 1);
  localparam int POS_W       = 5;
  localparam int LEN_W       = 16;

  typedef struct packed {
    logic [LEN_W-1:0] row_length;
    logic             last_row;
  } row_item_t;

  typedef struct packed {
    logic [POS_W-1:0] original_position;
    logic [LEN_W-1:0] sorted_length;
    logic             last_result;
    logic             overflow;
  } result_item_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_SLOT,
    RD_PROBE,
    RD_OUT
  } rd_kind_t;

  typedef struct packed {
    logic load;
    logic start_sort;
    logic rd_slot;
    logic rd_probe;
    logic rd_out;
    logic wr_slot;
    logic wr_best;
    logic next_slot;
    logic start_out;
    logic next_out;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic             sort_done;
    logic             probe_last;
    logic             found;
    logic             out_last;
    logic             out_fire;
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

// ===== hw/rtl/rlss_datapath.sv =====
module rlss_datapath import rlss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_status_t   status,
  input  row_item_t    row,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  logic [LENGTH_BITS-1:0] key_mem [MAX_ROWS];
  logic [IDX_W-1:0]       tag_mem [MAX_ROWS];

  logic [CNT_W-1:0]       count;
  logic                   overflow_seen;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       probe;
  logic [IDX_W-1:0]       out_idx;
  rd_kind_t               rd_kind;
  logic [IDX_W-1:0]       rd_idx;
  logic [LENGTH_BITS-1:0] rd_key;
  logic [IDX_W-1:0]       rd_tag;
  logic [LENGTH_BITS-1:0] best_key;
  logic [IDX_W-1:0]       best_tag;
  logic [IDX_W-1:0]       best_idx;
  logic [LENGTH_BITS-1:0] slot_key;
  logic [IDX_W-1:0]       slot_tag;
  logic                   found;

  logic                   full;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [LENGTH_BITS-1:0] wr_key;
  logic [IDX_W-1:0]       wr_tag;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  rd_kind_t               rd_kind_next;
  logic                   out_fire;

  assign full     = (count == CNT_W'(MAX_ROWS));
  assign out_fire = result_valid && !result_stall;

  // Single write port: load, then the two halves of a swap.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_key  = LENGTH_BITS'(row.row_length);
    wr_tag  = count[IDX_W-1:0];
    priority if (cmd.load && !full) begin
      wr_en = 1'b1;
    end else if (cmd.wr_slot) begin
      wr_en   = 1'b1;
      wr_addr = slot;
      wr_key  = best_key;
      wr_tag  = best_tag;
    end else if (cmd.wr_best) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_key  = slot_key;
      wr_tag  = slot_tag;
    end
  end

  always_comb begin
    rd_en        = cmd.rd_slot || cmd.rd_probe || cmd.rd_out;
    rd_addr      = out_idx;
    rd_kind_next = RD_NONE;
    priority if (cmd.rd_slot) begin
      rd_addr      = slot;
      rd_kind_next = RD_SLOT;
    end else if (cmd.rd_probe) begin
      rd_addr      = probe;
      rd_kind_next = RD_PROBE;
    end else if (cmd.rd_out) begin
      rd_kind_next = RD_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_tag <= tag_mem[rd_addr];
    end
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      rd_kind       <= RD_NONE;
      result_valid  <= 1'b0;
    end else begin
      rd_kind <= rd_kind_next;
      if (cmd.finish) begin
        count         <= '0;
        overflow_seen <= 1'b0;
      end else if (cmd.load) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (rd_kind == RD_OUT) begin
        result_valid <= 1'b1;
      end else if (out_fire) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sort) begin
      slot <= '0;
    end else if (cmd.next_slot) begin
      slot <= slot + IDX_W'(1);
    end
    if (cmd.rd_slot) begin
      probe <= slot + IDX_W'(1);
    end else if (cmd.rd_probe) begin
      probe <= probe + IDX_W'(1);
    end
    if (cmd.start_out) begin
      out_idx <= '0;
    end else if (cmd.next_out) begin
      out_idx <= out_idx + IDX_W'(1);
    end
    // Slot data opens a pass; each probe keeps the first strict minimum.
    unique case (rd_kind)
      RD_SLOT: begin
        best_key <= rd_key;
        best_tag <= rd_tag;
        best_idx <= rd_idx;
        slot_key <= rd_key;
        slot_tag <= rd_tag;
        found    <= 1'b0;
      end
      RD_PROBE: begin
        if (rd_key < best_key) begin
          best_key <= rd_key;
          best_tag <= rd_tag;
          best_idx <= rd_idx;
          found    <= 1'b1;
        end
      end
      RD_OUT: begin
        result.original_position <= POS_W'(rd_tag);
        result.sorted_length     <= LEN_W'(rd_key);
        result.last_result       <= status.out_last;
        result.overflow          <= overflow_seen;
      end
      default: begin
      end
    endcase
  end

  assign status.sort_done  = (CNT_W'(slot) + CNT_W'(1)) >= count;
  assign status.probe_last = (CNT_W'(probe) + CNT_W'(1)) == count;
  assign status.found      = found;
  assign status.out_last   = (CNT_W'(out_idx) + CNT_W'(1)) == count;
  assign status.out_fire   = out_fire;
  assign status.count      = count;

endmodule

// ===== hw/rtl/rlss_controller.sv =====
module rlss_controller import rlss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       row_valid,
  input  logic       last_row,
  output logic       row_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_SCAN,
    S_LAST,
    S_SWAP_A,
    S_SWAP_B,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load = row_valid;
        if (row_valid && last_row) begin
          cmd.start_sort = 1'b1;
          state_next     = S_PASS;
        end
      end
      S_PASS: begin
        if (status.sort_done) begin
          cmd.start_out = 1'b1;
          state_next    = S_OUT_RD;
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_probe = 1'b1;
        if (status.probe_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        // let the final probe compare settle
        state_next = S_SWAP_A;
      end
      S_SWAP_A: begin
        if (status.found) begin
          cmd.wr_slot = 1'b1;
          state_next  = S_SWAP_B;
        end else begin
          cmd.next_slot = 1'b1;
          state_next    = S_PASS;
        end
      end
      S_SWAP_B: begin
        cmd.wr_best   = 1'b1;
        cmd.next_slot = 1'b1;
        state_next    = S_PASS;
      end
      S_OUT_RD: begin
        cmd.rd_out = 1'b1;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        state_next = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (status.out_fire) begin
          if (status.out_last) begin
            cmd.finish = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.next_out = 1'b1;
            state_next   = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign row_stall = (state != S_LOAD);

endmodule

// ===== hw/rtl/row_length_selection_sort.sv =====
// Row length selection sort.
// Input channel (row_valid / row_stall / row): one row request per cycle while
// loading; each row carries its length and a last_row mark. Rows are tagged
// by load position. Rows past capacity are dropped and flag overflow.
// The request marked last_row closes the set: row_stall rises and the stored
// rows are sorted by length, ascending, in a row memory with one write port
// and one read port. Each sort pass over slot s reads the slot row, then
// probes every later row, one memory read per compare, and a swap writes
// both rows back.
// Output channel (result_valid / result_stall / result): one result per row
// in sorted order, with last_result on the final one; each result goes
// through a memory read, an output register load and the handoff. The result
// register holds while result_stall is high and no further read is issued.
// After the final result is taken the block returns to loading.
// Reset empties the set and clears any pending result; memory contents are
// not cleared, since every entry is written before it is read.
module row_length_selection_sort import rlss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         row_valid,
  output logic         row_stall,
  input  row_item_t    row,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rlss_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .last_row  (row.last_row),
    .row_stall (row_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rlss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // no new rows while a result is pending
  a_no_load_with_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> row_stall)
    else $error("row accepted while a result is pending");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_last_closes_set: assert property (@(posedge clk) disable iff (rst)
    (row_valid && !row_stall && row.last_row) |=> row_stall)
    else $error("input still open after the last row");

  a_swap_needs_min: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_slot |-> status.found)
    else $error("swap without a smaller row");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import rlss_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 100;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         row_valid = 1'b0;
  logic         row_stall;
  row_item_t    row = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;

  // Sorting state of the current set, as the block should hold it.
  logic [LEN_W-1:0] held_length [MAX_ROWS];
  logic [POS_W-1:0] held_position [MAX_ROWS];
  int               held_count = 0;
  logic             held_dropped = 1'b0;
  result_item_t     sorted_order [$];

  row_length_selection_sort u_dut (
    .clk          (clk),
    .rst          (rst),
    .row_valid    (row_valid),
    .row_stall    (row_stall),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // A new hold-off request starts a long stall; otherwise stall at random.
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done   <= holds_done + 1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void add_row_to_set(row_item_t item);
    int               n;
    int               best;
    bit               found;
    logic [LEN_W-1:0] len_tmp;
    logic [POS_W-1:0] pos_tmp;
    result_item_t     r;
    if (held_count < MAX_ROWS) begin
      held_length[held_count]   = item.row_length;
      held_position[held_count] = held_count[POS_W-1:0];
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!item.last_row)
      return;
    n = held_count;
    for (int s = 0; s + 1 < n; s++) begin
      best  = s;
      found = 1'b0;
      // keep the first strict minimum; the swap can still change the order of ties
      for (int p = s + 1; p < n; p++) begin
        if (held_length[p] < held_length[best]) begin
          best  = p;
          found = 1'b1;
        end
      end
      if (found) begin
        len_tmp              = held_length[best];
        pos_tmp              = held_position[best];
        held_length[best]    = held_length[s];
        held_position[best]  = held_position[s];
        held_length[s]       = len_tmp;
        held_position[s]     = pos_tmp;
      end
    end
    for (int k = 0; k < n; k++) begin
      r.original_position = held_position[k];
      r.sorted_length     = held_length[k];
      r.last_result       = (k == n - 1);
      r.overflow          = held_dropped;
      sorted_order.push_back(r);
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (sorted_order.size() == 0) begin
        $error("result with nothing expected: position %0d length %0d",
               result.original_position, result.sorted_length);
        fail_count++;
      end else begin
        want = sorted_order.pop_front();
        check_field("original_position", 32'(want.original_position),
                    32'(result.original_position));
        check_field("sorted_length", 32'(want.sorted_length), 32'(result.sorted_length));
        check_field("last_result", 32'(want.last_result), 32'(result.last_result));
        check_field("overflow", 32'(want.overflow), 32'(result.overflow));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_row(input logic [LEN_W-1:0] len, input logic last);
    row_item_t item;
    item.row_length = len;
    item.last_row   = last;
    while ($urandom_range(99) < tx_idle_pct) begin
      row_valid <= 1'b0;
      @(negedge clk);
    end
    row_valid <= 1'b1;
    row       <= item;
    do @(posedge clk); while (row_stall);
    add_row_to_set(item);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    row_valid <= 1'b0;
    while (sorted_order.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return LEN_W'($urandom_range(7));
      default: return LEN_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++)
      send_row(pick_length(), i == size - 1);
  endtask

  task automatic test_single_rows();
    send_row(16'h0000, 1'b1);
    send_row(16'hFFFF, 1'b1);
    send_row(16'hA5A5, 1'b1);
  endtask

  task automatic test_ties();
    send_row(16'd7, 1'b0);
    send_row(16'd3, 1'b0);
    send_row(16'd7, 1'b0);
    send_row(16'd3, 1'b1);
    send_row(16'd9, 1'b0);
    send_row(16'd9, 1'b0);
    send_row(16'd9, 1'b1);
  endtask

  task automatic test_extremes();
    send_row(16'hFFFF, 1'b0);
    send_row(16'h0000, 1'b0);
    send_row(16'h0001, 1'b0);
    send_row(16'hFFFE, 1'b0);
    send_row(16'h8000, 1'b1);
  endtask

  // Fill the set exactly, then overflow it so the closing request is dropped.
  task automatic test_capacity();
    send_set(MAX_ROWS + 1);
  endtask

  task automatic test_random_sets(input int budget);
    int sent;
    int size;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 70)      size = $urandom_range(6, 1);
      else if (pick < 90) size = $urandom_range(20, 7);
      else if (pick < 97) size = MAX_ROWS;
      else                size = $urandom_range(MAX_ROWS + 4, MAX_ROWS + 1);
      send_set(size);
      sent += size;
    end
  endtask

  task automatic test_backpressure();
    int saved_idle;
    saved_idle  = tx_idle_pct;
    tx_idle_pct = 0;
    holds_asked++;
    send_set(5);
    send_set(5);
    tx_idle_pct = saved_idle;
  endtask

  task automatic test_drain_pause();
    send_set(4);
    wait_drained();
    send_set(3);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 28;
    rx_idle_pct = 59;
    test_single_rows();
    test_ties();
    test_extremes();
    test_capacity();
    test_random_sets(10);
    test_backpressure();

    tx_idle_pct = 59;
    rx_idle_pct = 28;
    test_random_sets(10);
    test_drain_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_sets(10);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sorted_order.size() != 0) begin
      $error("%0d results never arrived", sorted_order.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rlss_pkg.sv
hw/rtl/rlss_datapath.sv
hw/rtl/rlss_controller.sv
hw/rtl/row_length_selection_sort.sv
test/tb_top.sv
